// ===== rtl/bole_pkg.sv =====
package bole_pkg;

    localparam int CAPACITY_DEF = 8;

    localparam int CMD_W  = 4;
    localparam int POS_W  = 3;
    localparam int DATA_W = 32;
    localparam int FPOS_W = 4;
    localparam int CNT_W  = 4;

    localparam logic [CMD_W-1:0] CMD_APPEND       = 4'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT       = 4'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE_AT    = 4'd2;
    localparam logic [CMD_W-1:0] CMD_REMOVE_FIRST = 4'd3;
    localparam logic [CMD_W-1:0] CMD_REMOVE_ALL   = 4'd4;
    localparam logic [CMD_W-1:0] CMD_UPDATE_AT    = 4'd5;
    localparam logic [CMD_W-1:0] CMD_UPDATE_MATCH = 4'd6;
    localparam logic [CMD_W-1:0] CMD_READ_AT      = 4'd7;
    localparam logic [CMD_W-1:0] CMD_FIND         = 4'd8;

    // found_position when nothing matched (-1 in four bits)
    localparam logic [FPOS_W-1:0] FPOS_NONE = '1;

    typedef enum logic [2:0] {
        C_HOLD,
        C_CMP,
        C_WRITE,
        C_INSERT,
        C_REMOVE
    } t_cell_op;

    typedef struct packed {
        t_cell_op          op;
        logic              by_match;
        logic [DATA_W-1:0] data;
    } t_cell_ctrl;

endpackage

// ===== rtl/bole_if.sv =====
interface bole_cmd_if import bole_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [CMD_W-1:0]         command;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] replacement;

    modport source (output valid, command, position, value, replacement, input ready);
    modport sink   (input valid, command, position, value, replacement, output ready);
endinterface

interface bole_rsp_if import bole_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic                     ok;
    logic signed [DATA_W-1:0] read_value;
    logic signed [FPOS_W-1:0] found_position;
    logic [CNT_W-1:0]         count;

    modport source (output valid, ok, read_value, found_position, count, input ready);
    modport sink   (input valid, ok, read_value, found_position, count, output ready);
endinterface

// ===== rtl/bole_cell.sv =====
module bole_cell import bole_pkg::*; #(
    parameter int IDX = 0,
    parameter int IW  = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cell_ctrl        i_ctrl,
    input  logic [IW-1:0]     i_pos,
    input  logic [DATA_W-1:0] i_dn_value,
    input  logic              i_dn_live,
    input  logic [DATA_W-1:0] i_up_value,
    input  logic              i_up_live,
    input  logic              i_up_hit,
    input  logic              i_hit_below,
    output logic [DATA_W-1:0] o_value,
    output logic              o_live,
    output logic              o_hit,
    output logic              o_hit_thru,
    output logic              o_first
);

    localparam logic [IW-1:0] MY_IDX = IW'(IDX);

    logic [DATA_W-1:0] r_value, n_value;
    logic              r_live, n_live;
    logic              r_hit, n_hit;
    logic              w_at, w_ge, w_above;

    assign o_value    = r_value;
    assign o_live     = r_live;
    assign o_hit      = r_hit & r_live;
    assign o_hit_thru = i_hit_below | o_hit;
    assign o_first    = o_hit & ~i_hit_below;

    // by_match: target is the first live hit in the chain
    assign w_at    = i_ctrl.by_match ? o_first    : (MY_IDX == i_pos);
    assign w_ge    = i_ctrl.by_match ? o_hit_thru : (MY_IDX >= i_pos);
    assign w_above = MY_IDX > i_pos;

    always_comb begin
        n_value = r_value;
        n_live  = r_live;
        n_hit   = r_hit;
        unique case (i_ctrl.op)
            C_HOLD: begin
            end
            C_CMP: begin
                n_hit = r_live && (r_value == i_ctrl.data);
            end
            C_WRITE: begin
                if (w_at) begin
                    n_value = i_ctrl.data;
                    n_live  = 1'b1;
                end
            end
            C_INSERT: begin
                if (w_at) begin
                    n_value = i_ctrl.data;
                    n_live  = 1'b1;
                end else if (w_above) begin
                    n_value = i_dn_value;
                    n_live  = i_dn_live;
                end
            end
            C_REMOVE: begin
                if (w_ge) begin
                    n_value = i_up_value;
                    n_live  = i_up_live;
                    n_hit   = i_up_hit;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live <= 1'b0;
            r_hit  <= 1'b0;
        end else begin
            r_live <= n_live;
            r_hit  <= n_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

endmodule

// ===== rtl/bounded_ordered_list_engine.sv =====
// Ordered list of up to CAPACITY signed 32-bit entries held in a chain of cells, one entry per
// cell, with a live bit per cell and an entry count. Each command request on i_cmd (append,
// insert, remove at a position, remove first match, remove all matches, update at a position,
// update first match, read, find) returns exactly one response on o_rsp with ok, read value,
// found position (-1 when absent) and the count after the command. A command passes through
// the accept cycle, in which every cell compares its entry to the request value, and then
// execute, in which cells shift one step toward or away from their neighbor or write in
// place. Remove-all stays in execute while a match is left, as the chain drops one matching
// entry per cycle. The response sits in an output register; while it waits to be taken the
// engine finishes no further command, and a new request is taken only between commands.

module bounded_ordered_list_engine import bole_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    bole_cmd_if.sink       i_cmd,
    bole_rsp_if.source     o_rsp
);

    localparam int IW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;  // cell index width
    localparam int CW   = $clog2(CAPACITY + 1);                   // count width
    localparam int CMPW = CW + POS_W;
    localparam int RD_N = (CAPACITY < 8) ? CAPACITY : 8;          // cells a position reaches

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state r_state, n_state;

    // latched request
    logic [CMD_W-1:0]  r_cmd;
    logic [POS_W-1:0]  r_pos;
    logic [DATA_W-1:0] r_value;
    logic [DATA_W-1:0] r_repl;
    logic              r_removed, n_removed;

    logic [CW-1:0]     r_count, n_count;

    // response register
    logic              r_out_valid, n_out_valid;
    logic              r_ok;
    logic [DATA_W-1:0] r_rd;
    logic [FPOS_W-1:0] r_fp;
    logic [CNT_W-1:0]  r_cnt;

    // chain
    t_cell_ctrl        w_ctrl;
    logic [IW-1:0]     w_pos;
    logic [DATA_W-1:0] w_value [CAPACITY];
    logic              w_live  [CAPACITY];
    logic              w_hit   [CAPACITY];
    logic              w_thru  [CAPACITY];
    logic              w_first [CAPACITY];

    logic              w_accept, w_out_free, w_full, w_pos_valid, w_any_hit;
    logic              w_finish, w_load;
    logic              w_ok;
    logic [DATA_W-1:0] w_rd, w_read_mux;
    logic [FPOS_W-1:0] w_fp, w_first_idx;

    assign i_cmd.ready    = (r_state == S_IDLE);
    assign w_accept       = i_cmd.valid && i_cmd.ready;

    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.ok             = r_ok;
    assign o_rsp.read_value     = r_rd;
    assign o_rsp.found_position = r_fp;
    assign o_rsp.count          = r_cnt;

    assign w_out_free  = !r_out_valid || o_rsp.ready;
    assign w_full      = (r_count == CW'(CAPACITY));
    assign w_pos_valid = (CMPW'(r_pos) < CMPW'(r_count));
    assign w_any_hit   = w_thru[CAPACITY-1];

    generate
        for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
            logic [DATA_W-1:0] w_dn_value, w_up_value;
            logic              w_dn_live, w_up_live, w_up_hit, w_below;

            if (g == 0) begin : g_first
                assign w_dn_value = '0;
                assign w_dn_live  = 1'b0;
                assign w_below    = 1'b0;
            end else begin : g_mid
                assign w_dn_value = w_value[g-1];
                assign w_dn_live  = w_live[g-1];
                assign w_below    = w_thru[g-1];
            end

            if (g == CAPACITY - 1) begin : g_last
                assign w_up_value = '0;
                assign w_up_live  = 1'b0;
                assign w_up_hit   = 1'b0;
            end else begin : g_inner
                assign w_up_value = w_value[g+1];
                assign w_up_live  = w_live[g+1];
                assign w_up_hit   = w_hit[g+1];
            end

            bole_cell #(
                .IDX (g),
                .IW  (IW)
            ) u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_ctrl      (w_ctrl),
                .i_pos       (w_pos),
                .i_dn_value  (w_dn_value),
                .i_dn_live   (w_dn_live),
                .i_up_value  (w_up_value),
                .i_up_live   (w_up_live),
                .i_up_hit    (w_up_hit),
                .i_hit_below (w_below),
                .o_value     (w_value[g]),
                .o_live      (w_live[g]),
                .o_hit       (w_hit[g]),
                .o_hit_thru  (w_thru[g]),
                .o_first     (w_first[g])
            );
        end
    endgenerate

    // read port: a 3-bit position only reaches the lowest cells
    always_comb begin
        w_read_mux = '0;
        for (int i = 0; i < RD_N; i++) begin
            if (r_pos == POS_W'(i)) begin
                w_read_mux = w_value[i];
            end
        end
    end

    // first hit is one-hot, so an OR of the indexes encodes it
    always_comb begin
        w_first_idx = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (w_first[i]) begin
                w_first_idx = w_first_idx | FPOS_W'(i);
            end
        end
    end

    // remove-all keeps looping while a live hit is left
    assign w_finish = !((r_cmd == CMD_REMOVE_ALL) && w_any_hit);
    assign w_load   = (r_state == S_EXEC) && w_finish && w_out_free;

    always_comb begin
        w_ctrl.op       = C_HOLD;
        w_ctrl.by_match = 1'b0;
        w_ctrl.data     = r_value;
        w_pos           = IW'(r_pos);
        w_ok            = 1'b0;
        w_rd            = '0;
        w_fp            = '0;
        n_count         = r_count;
        n_removed       = r_removed;

        if (r_state == S_IDLE) begin
            // compare against the incoming value so hits are ready at execute
            w_ctrl.op   = C_CMP;
            w_ctrl.data = i_cmd.value;
            n_removed   = 1'b0;
        end else if (!w_finish || w_out_free) begin
            unique case (r_cmd)
                CMD_APPEND: begin
                    if (!w_full) begin
                        w_ctrl.op = C_WRITE;
                        w_pos     = IW'(r_count);
                        w_ok      = 1'b1;
                        n_count   = r_count + CW'(1);
                    end
                end
                CMD_INSERT: begin
                    if (!w_full && w_pos_valid) begin
                        w_ctrl.op = C_INSERT;
                        w_ok      = 1'b1;
                        n_count   = r_count + CW'(1);
                    end
                end
                CMD_REMOVE_AT: begin
                    if (w_pos_valid) begin
                        w_ctrl.op = C_REMOVE;
                        w_ok      = 1'b1;
                        n_count   = r_count - CW'(1);
                    end
                end
                CMD_REMOVE_FIRST: begin
                    if (w_any_hit) begin
                        w_ctrl.op       = C_REMOVE;
                        w_ctrl.by_match = 1'b1;
                        w_ok            = 1'b1;
                        n_count         = r_count - CW'(1);
                    end
                end
                CMD_REMOVE_ALL: begin
                    if (w_any_hit) begin
                        w_ctrl.op       = C_REMOVE;
                        w_ctrl.by_match = 1'b1;
                        n_count         = r_count - CW'(1);
                        n_removed       = 1'b1;
                    end else begin
                        w_ok = r_removed;
                    end
                end
                CMD_UPDATE_AT: begin
                    if (w_pos_valid) begin
                        w_ctrl.op = C_WRITE;
                        w_ok      = 1'b1;
                    end
                end
                CMD_UPDATE_MATCH: begin
                    if (w_any_hit) begin
                        w_ctrl.op       = C_WRITE;
                        w_ctrl.by_match = 1'b1;
                        w_ctrl.data     = r_repl;
                        w_ok            = 1'b1;
                    end
                end
                CMD_READ_AT: begin
                    if (w_pos_valid) begin
                        w_rd = w_read_mux;
                        w_ok = 1'b1;
                    end
                end
                CMD_FIND: begin
                    if (w_any_hit) begin
                        w_fp = w_first_idx;
                        w_ok = 1'b1;
                    end else begin
                        w_fp = FPOS_NONE;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (w_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_load) begin
            n_out_valid = 1'b1;
        end else if (o_rsp.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_removed   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_removed   <= n_removed;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd   <= i_cmd.command;
            r_pos   <= i_cmd.position;
            r_value <= i_cmd.value;
            r_repl  <= i_cmd.replacement;
        end
        if (w_load) begin
            r_ok  <= w_ok;
            r_rd  <= w_rd;
            r_fp  <= w_fp;
            r_cnt <= CNT_W'(n_count);
        end
    end

endmodule
